// ===== design/chained_hash_multimap_unit_defines.svh =====
// ----------------------------------------------------------------------------
// chained_hash_multimap_unit_defines.svh
// Assertion macros shared by the hash multimap RTL.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MULTIMAP_UNIT_DEFINES_SVH
`define CHAINED_HASH_MULTIMAP_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CHMU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CHMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/chmu_pkg.sv =====
// ----------------------------------------------------------------------------
// chmu_pkg
// Types and fixed constants of the chained hash multimap.
// ----------------------------------------------------------------------------
`default_nettype none

package chmu_pkg;

  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int HASH_BITS  = 4;                    // key bits folded per cycle
  localparam int HASH_STEPS = 8;                    // fold steps per remainder
  localparam int KEY_PAD_W  = HASH_BITS * HASH_STEPS;
  localparam int HCNT_W     = $clog2(HASH_STEPS);

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FILL,
    S_DECIDE,
    S_RD,
    S_CHK,
    S_LAST
  } state_t;

endpackage

`default_nettype wire

// ===== design/chained_hash_multimap_unit.sv =====
// Usage:
// Input channel (in_valid/in_stall) carries one beat per operation: in_func
// selects insert (store in_key/in_item_value) or lookup (find in_key).
// Result channel (out_valid/out_stall) returns one beat per insert (inserted
// or bucket full) and one or more beats per lookup: every stored value of
// the key, newest first, or one no-values beat. out_last marks the final beat
// of an operation.
// After reset the block clears its bucket fill counters, one per cycle, and
// holds in_stall high until all of them are cleared.
// One operation is taken at a time. The bucket index comes from a remainder
// unit that folds four key bits per cycle, then the fill count is read from
// its memory. A lookup visits the bucket's entries one by one, as the single
// entry memory read port allows.
// A stalled receiver holds the result register; the sequencer waits on it
// and stops taking beats until the pending result can move.
// ----------------------------------------------------------------------------
// chained_hash_multimap_unit
// Hash multimap with fixed-depth buckets and key-filtered lookups.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chained_hash_multimap_unit_defines.svh"

module chained_hash_multimap_unit #(
  parameter int BUCKETS      = 16,
  parameter int BUCKET_DEPTH = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_func,
  input  wire logic [chmu_pkg::KEY_W-1:0]          in_key,
  input  wire logic signed [chmu_pkg::VAL_W-1:0]   in_item_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output chmu_pkg::status_t                        out_status,
  output logic signed [chmu_pkg::VAL_W-1:0]        out_found_value,
  output logic                                     out_last
);
  import chmu_pkg::*;

  localparam int BW    = $clog2(BUCKETS);
  localparam int FW    = $clog2(BUCKET_DEPTH + 1);
  localparam int IW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int SLOTS = BUCKETS * BUCKET_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int EW    = KEY_W + VAL_W;

  // storage
  logic [EW-1:0] ent_mem  [SLOTS];
  logic [FW-1:0] fill_mem [BUCKETS];

  state_t                state_r, state_nxt;
  logic [BW-1:0]         clr_cnt_r;
  logic [HCNT_W-1:0]     hcnt_r;
  logic [KEY_PAD_W-1:0]  key_sh_r;
  logic [BW-1:0]         rem_r;
  logic                  func_r;
  logic [KEY_W-1:0]      key_r;
  logic [VAL_W-1:0]      val_r;
  logic [AW-1:0]         base_r;
  logic [IW-1:0]         idx_r;
  logic                  pend_r;
  logic [VAL_W-1:0]      pend_val_r;
  status_t               res_status_r;
  logic [VAL_W-1:0]      res_value_r;
  logic [FW-1:0]         fill_q_r;
  logic [EW-1:0]         ent_q_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [VAL_W-1:0]      out_value_r;
  logic                  out_last_r;

  logic                  in_take;
  logic                  out_free;
  logic [BW-1:0]         rem_step;
  logic                  clr_done;
  logic                  fill_full;
  logic                  ent_match;
  logic                  chk_hold;
  logic                  ins_we;
  logic                  push;
  status_t               push_status;
  logic [VAL_W-1:0]      push_value;
  logic                  push_last;
  logic [AW-1:0]         ent_raddr;
  logic [AW-1:0]         ent_waddr;

  assign out_free  = !out_valid_r || !out_stall;
  assign clr_done  = (clr_cnt_r == BW'(BUCKETS - 1));
  assign fill_full = (fill_q_r >= FW'(BUCKET_DEPTH));
  assign ent_match = (ent_q_r[EW-1:VAL_W] == key_r);
  assign chk_hold  = ent_match && pend_r && !out_free;
  assign ent_raddr = base_r + AW'(idx_r);
  assign ent_waddr = base_r + AW'(fill_q_r[IW-1:0]);

  // remainder unit: shift HASH_BITS key bits into the partial remainder
  always_comb begin
    logic [BW:0]   t;
    logic [BW-1:0] r;
    r = rem_r;
    for (int j = 0; j < HASH_BITS; j++) begin
      t = {r, key_sh_r[KEY_PAD_W-1-j]};
      if (t >= (BW+1)'(BUCKETS)) t = t - (BW+1)'(BUCKETS);
      r = t[BW-1:0];
    end
    rem_step = r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_HASH;
      S_HASH:   if (hcnt_r == HCNT_W'(HASH_STEPS - 1)) state_nxt = S_FILL;
      S_FILL:   state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (func_r == FN_LOOKUP && fill_q_r != '0) state_nxt = S_RD;
        else state_nxt = S_LAST;
      end
      S_RD:     state_nxt = S_CHK;
      S_CHK: begin
        if (chk_hold) state_nxt = S_CHK;
        else if (idx_r == '0) state_nxt = S_LAST;
        else state_nxt = S_RD;
      end
      S_LAST:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall    = 1'b1;
    ins_we      = 1'b0;
    push        = 1'b0;
    push_status = res_status_r;
    push_value  = res_value_r;
    push_last   = 1'b1;
    unique case (state_r)
      S_IDLE:   in_stall = 1'b0;
      S_DECIDE: ins_we = (func_r == FN_INSERT) && !fill_full;
      S_CHK: begin
        // an earlier match is known not to be last once another one shows up
        if (ent_match && pend_r && out_free) begin
          push        = 1'b1;
          push_status = ST_FOUND;
          push_value  = pend_val_r;
          push_last   = 1'b0;
        end
      end
      S_LAST:   push = out_free;
      default:  in_stall = 1'b1;
    endcase
  end

  assign in_take = in_valid && !in_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      hcnt_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (in_take) hcnt_r <= '0;
      else if (state_r == S_HASH) hcnt_r <= hcnt_r + 1'b1;
      if (state_r == S_DECIDE) pend_r <= 1'b0;
      else if (state_r == S_CHK && !chk_hold && ent_match) pend_r <= 1'b1;
      if (push) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r   <= in_func;
      key_r    <= in_key;
      val_r    <= in_item_value;
      key_sh_r <= {1'b0, in_key};
      rem_r    <= '0;
    end else if (state_r == S_HASH) begin
      key_sh_r <= key_sh_r << HASH_BITS;
      rem_r    <= rem_step;
    end

    if (state_r == S_FILL) base_r <= AW'(rem_r) * AW'(BUCKET_DEPTH);

    if (state_r == S_DECIDE) begin
      idx_r       <= IW'(fill_q_r - 1'b1);
      res_value_r <= '0;
      if (func_r == FN_INSERT) res_status_r <= fill_full ? ST_FULL : ST_INSERTED;
      else res_status_r <= ST_NONE;
    end

    if (state_r == S_CHK && !chk_hold) begin
      if (ent_match) pend_val_r <= ent_q_r[VAL_W-1:0];
      if (idx_r != '0) begin
        idx_r <= idx_r - 1'b1;
      end else begin
        res_status_r <= (ent_match || pend_r) ? ST_FOUND : ST_NONE;
        if (ent_match) res_value_r <= ent_q_r[VAL_W-1:0];
        else if (pend_r) res_value_r <= pend_val_r;
        else res_value_r <= '0;
      end
    end

    if (push) begin
      out_status_r <= push_status;
      out_value_r  <= push_value;
      out_last_r   <= push_last;
    end
  end

  // bucket fill memory: cleared after reset, bumped on insert
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) fill_mem[clr_cnt_r] <= '0;
    else if (ins_we) fill_mem[rem_r] <= fill_q_r + 1'b1;
    fill_q_r <= fill_mem[rem_r];
  end

  // entry memory: {key, value} per slot
  always_ff @(posedge clk) begin
    if (ins_we) ent_mem[ent_waddr] <= {key_r, val_r};
    ent_q_r <= ent_mem[ent_raddr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;
  assign out_last        = out_last_r;

  `CHMU_ASSERT_NOW(a_bucket_range, clk, rst_n, state_r == S_FILL,
    rem_r < BW'(BUCKETS - 1) || rem_r == BW'(BUCKETS - 1), "bucket index out of range")
  `CHMU_ASSERT_NOW(a_fill_range, clk, rst_n, state_r == S_DECIDE,
    fill_q_r <= FW'(BUCKET_DEPTH), "bucket fill count above depth")
  `CHMU_ASSERT_NEXT(a_full_drop, clk, rst_n,
    state_r == S_DECIDE && func_r == FN_INSERT && fill_full,
    res_status_r == ST_FULL, "full bucket not reported")
  `CHMU_ASSERT_NOW(a_only_found_open, clk, rst_n,
    out_valid_r && out_status_r != ST_FOUND, out_last_r, "non-value beat without last")

endmodule

`default_nettype wire
